FILE: hdl/srir_pkg.sv
// shared types and constants for the sample recorder / interpolating resampler
// used by the top level
package srir_pkg;
  localparam int RowDepth    = 1024;
  localparam int MaxElements = 16;
  localparam int RowAw       = $clog2(RowDepth);
  localparam int ElemAw      = $clog2(MaxElements);
  localparam int ValAw       = RowAw + ElemAw;
  localparam int CountW      = RowAw + 1;
  localparam int TimeW       = 48;
  localparam int ValW        = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_CLAMP  = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_WT, S_SRCH_CMP, S_TF_RD, S_TF_WT, S_TS_WT,
    S_FAC, S_DIV, S_EL_RD, S_EL_WT, S_VF_MUL, S_VS_MUL, S_OUT
  } state_e;
endpackage

FILE: hdl/srir_ram.sv
// generic single port ram with registered read
// no dependencies
module srir_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/sample_recorder_interpolating_resampler_top.sv
// Records rows of up to 16 signed Q16.16 elements stamped with Q32.16 times
// (1024 rows) and answers queries with linearly interpolated rows. A record
// or clear beat acts as soon as it is accepted. A query does a binary search
// (up to 11 probes, each a read, wait and compare step), reads the end rows,
// runs a bit-serial 17-bit factor division when the query time lies strictly
// between two row times, then weights each element, all through one shared
// multiplier and two single port rams. An empty store gives a zero result
// per element. Each result waits in an output register; the block is not
// ready during a query. The stores need no clearing pass, so the block is
// ready right after reset.
// depends on srir_pkg and srir_ram
module sample_recorder_interpolating_resampler_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] sample_time, [79:48] element_value, [127:80] query_time
  input  logic [127:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] interpolated_value, [35:32] element_index, [36] store_overflowed,
  // zero filled to 40
  output logic [39:0]  m_axis_tdata,
  // [1:0] query_status
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import srir_pkg::*;

  state_e state_q, state_d;

  logic [4:0]            eps_reg_q;
  logic [ElemAw:0]       eps;
  logic [CountW-1:0]     row_count_q;
  logic [ElemAw-1:0]     pend_q;
  logic                  ovf_q;

  logic [TimeW-1:0]      qtime_q;
  logic [CountW-1:0]     left_q, right_q;
  logic [RowAw-1:0]      f_q, s_q;
  logic [TimeW-1:0]      tf_q;
  logic [16:0]           fac_q;
  logic [TimeW+16:0]     rem_q;
  logic [TimeW-1:0]      den_q;
  logic [4:0]            bit_q;
  logic [ElemAw-1:0]     el_q;
  logic signed [ValW-1:0] vf_q;
  logic signed [34:0]    acc_q;
  logic [1:0]            status_q;

  logic [31:0]           out_val_q;
  logic [ElemAw-1:0]     out_idx_q;
  logic                  out_last_q, out_valid_q;
  logic [1:0]            out_st_q;
  logic                  out_ovf_q;

  logic                  cfg_wr;
  logic                  in_acc;
  opcode_e               op;
  logic [TimeW-1:0]      in_stime, in_qtime;
  logic [ValW-1:0]       in_val;

  logic                  t_we, v_we;
  logic [RowAw-1:0]      t_addr;
  logic [ValAw-1:0]      v_addr;
  logic [TimeW-1:0]      t_rd;
  logic [ValW-1:0]       v_rd;

  logic [CountW-1:0]     probe;
  logic signed [ValW-1:0]  mul_a;
  logic signed [17:0]    mul_b;
  logic signed [49:0]    mul_p;
  logic signed [33:0]    mul_fl;
  logic signed [34:0]    sum;
  logic [TimeW+16:0]     rem_sh;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = {27'd0, eps_reg_q};
  assign eps     = (eps_reg_q == 5'd0) ? (ElemAw+1)'(1) :
                   (eps_reg_q > 5'(MaxElements)) ? (ElemAw+1)'(MaxElements) :
                   eps_reg_q[ElemAw:0];

  assign op       = opcode_e'(s_axis_tuser);
  assign in_stime = s_axis_tdata[47:0];
  assign in_val   = s_axis_tdata[79:48];
  assign in_qtime = s_axis_tdata[127:80];
  assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  assign probe = CountW'((left_q + right_q) >> 1);

  // shared multiplier: value times factor or its complement
  assign mul_a  = (state_q == S_VF_MUL) ? vf_q : $signed(v_rd);
  assign mul_b  = (state_q == S_VF_MUL) ? $signed({1'b0, fac_q}) :
                  $signed({1'b0, 17'(17'h10000 - fac_q)});
  assign mul_p  = mul_a * mul_b;
  assign mul_fl = 34'(mul_p >>> 16);
  assign sum    = acc_q + 35'(mul_fl);
  assign rem_sh = {rem_q[TimeW+15:0], 1'b0};

  // ram ports
  always_comb begin
    t_we   = 1'b0;
    v_we   = 1'b0;
    t_addr = RowAw'(probe);
    v_addr = {RowAw'(row_count_q), pend_q};
    case (state_q)
      S_IDLE: begin
        t_addr = RowAw'(row_count_q);
        if (in_acc && op == OP_RECORD && row_count_q < CountW'(RowDepth)) begin
          v_we = 1'b1;
          t_we = (ElemAw+1)'(pend_q) + 1'b1 >= eps;
        end
      end
      S_TF_RD: t_addr = f_q;
      S_TF_WT, S_TS_WT: t_addr = s_q;
      S_EL_RD, S_EL_WT: v_addr = {f_q, el_q};
      S_VF_MUL: v_addr = {s_q, el_q};
      default: ;
    endcase
  end

  srir_ram #(.Width(TimeW), .Depth(RowDepth)) u_times (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(in_stime), .rdata_o(t_rd));
  srir_ram #(.Width(ValW), .Depth(RowDepth*MaxElements)) u_vals (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(in_val), .rdata_o(v_rd));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && op == OP_QUERY) begin
        state_d = (row_count_q == '0) ? S_OUT : S_SRCH_RD;
      end
      S_SRCH_RD:  state_d = (right_q > left_q) ? S_SRCH_WT : S_TF_RD;
      S_SRCH_WT:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_TF_RD:    state_d = S_TF_WT;
      S_TF_WT:    state_d = S_TS_WT;
      S_TS_WT:    state_d = S_FAC;
      S_FAC:      state_d = (tf_q < t_rd && qtime_q < t_rd && t_rd - qtime_q < t_rd - tf_q)
                            ? S_DIV : S_EL_RD;
      S_DIV:      state_d = (bit_q == 5'd0) ? S_EL_RD : S_DIV;
      S_EL_RD:    state_d = S_EL_WT;
      S_EL_WT:    state_d = S_VF_MUL;
      S_VF_MUL:   state_d = S_VS_MUL;
      S_VS_MUL:   state_d = S_OUT;
      S_OUT: if (!out_valid_q) begin
        if ((ElemAw+1)'(el_q) + 1'b1 >= eps) state_d = S_IDLE;
        else if (status_q == ST_EMPTY) state_d = S_OUT;
        else state_d = S_EL_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_reg_q   <= 5'd1;
      row_count_q <= '0;
      pend_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      el_q        <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_wr && paddr == 1'b0) begin
        eps_reg_q   <= pwdata[4:0];
        row_count_q <= '0;
        pend_q      <= '0;
        ovf_q       <= 1'b0;
      end else if (in_acc && op == OP_CLEAR) begin
        row_count_q <= '0;
        pend_q      <= '0;
        ovf_q       <= 1'b0;
      end else if (in_acc && op == OP_RECORD) begin
        if ((ElemAw+1)'(pend_q) + 1'b1 >= eps) begin
          pend_q <= '0;
          if (row_count_q < CountW'(RowDepth)) row_count_q <= row_count_q + 1'b1;
          else ovf_q <= 1'b1;
        end else begin
          pend_q <= pend_q + 1'b1;
        end
      end
      if (in_acc) el_q <= '0;
      if (state_q == S_OUT && !out_valid_q) begin
        out_valid_q <= 1'b1;
        el_q        <= el_q + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qtime_q  <= in_qtime;
      left_q   <= '0;
      right_q  <= row_count_q;
      status_q <= ST_EMPTY;
      acc_q    <= '0;
    end
    case (state_q)
      S_SRCH_CMP: begin
        if (t_rd > qtime_q) right_q <= probe;
        else if (t_rd < qtime_q) left_q <= probe + 1'b1;
        else begin
          // exact hit: close the window on the probe
          left_q  <= probe;
          right_q <= probe;
        end
      end
      default: ;
    endcase
    if (state_d == S_TF_RD && state_q != S_TF_RD) begin
      f_q <= (right_q != '0) ? RowAw'(right_q - 1'b1) : '0;
      s_q <= (right_q < row_count_q) ? RowAw'(right_q) : RowAw'(row_count_q - 1'b1);
    end
    if (state_q == S_TF_RD) status_q <= (f_q == s_q) ? ST_CLAMP : ST_INTERP;
    if (state_q == S_TF_WT) tf_q <= t_rd;
    if (state_q == S_FAC) begin
      den_q <= t_rd - tf_q;
      // numerator aligned so the first step yields the integer bit
      rem_q <= {2'd0, t_rd - qtime_q, 15'd0};
      bit_q <= 5'd16;
      fac_q <= (t_rd <= tf_q) ? 17'h10000 : (t_rd <= qtime_q) ? 17'd0 : 17'h10000;
    end
    // restoring division, one quotient bit a cycle
    if (state_q == S_DIV) begin
      if (bit_q == 5'd16) fac_q <= '0;
      if (rem_sh[TimeW+16:16] >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q, 16'd0};
        if (bit_q != 5'd16) fac_q <= {fac_q[15:0], 1'b1};
        else fac_q <= 17'd1;
      end else begin
        rem_q <= rem_sh;
        if (bit_q != 5'd16) fac_q <= {fac_q[15:0], 1'b0};
      end
      bit_q <= bit_q - 1'b1;
    end
    if (state_q == S_EL_WT) vf_q <= $signed(v_rd);
    if (state_q == S_VF_MUL) acc_q <= 35'(mul_fl);
    if (state_q == S_VS_MUL) acc_q <= sum;
    if (state_q == S_OUT && !out_valid_q) begin
      out_val_q  <= (status_q == ST_EMPTY) ? 32'd0 :
                    (acc_q > 35'sh7FFFFFFF) ? 32'h7FFFFFFF :
                    (acc_q < -35'sh80000000) ? 32'h80000000 : acc_q[31:0];
      out_idx_q  <= el_q;
      out_last_q <= (ElemAw+1)'(el_q) + 1'b1 >= eps;
      out_st_q   <= status_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {3'b0, out_ovf_q, 4'(out_idx_q), out_val_q};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_count_q <= CountW'(RowDepth)) else $error("row count overrun");
  a_fac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EL_RD |-> fac_q <= 17'h10000) else $error("factor above one");
endmodule
